FILE: rtl/rhsv_pkg.sv
// Shared constants and helpers for the RGB to HSV converter.
// No dependencies; imported by rhsv_front, the top level and rgb_to_hsv_checker.
package rhsv_pkg;

  // Hue sector offsets in sixths of a turn
  localparam int GreenOffset = 2;
  localparam int BlueOffset  = 4;
  localparam int TurnSixths  = 6;

  // Number of quotient steps shared by the hue and saturation dividers
  function automatic int div_steps(input int chan_bits, input int hue_bits);
    return (chan_bits > hue_bits) ? chan_bits : hue_bits;
  endfunction

endpackage

FILE: rtl/rhsv_front.sv
// Front stage: max/min, delta, hue numerator and divider operands, registered.
// Depends on rhsv_pkg.
module rhsv_front #(
  parameter int C = 8,
  parameter int H = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [C-1:0]                           red_i,
  input  logic [C-1:0]                           green_i,
  input  logic [C-1:0]                           blue_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [C+2:0]                           hue_rem_o,
  output logic [C+2:0]                           hue_div_o,
  output logic [C-1:0]                           sat_rem_o,
  output logic [C-1:0]                           sat_div_o,
  output logic [rhsv_pkg::div_steps(C, H)-1:0]   sat_low_o,
  output logic [C-1:0]                           value_o
);
  import rhsv_pkg::*;

  localparam int L   = div_steps(C, H);
  localparam int HRW = C + 3;
  localparam int NW  = C + 4;

  typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} sector_e;

  sector_e        sector;
  logic [C-1:0]   mx, mn, dl;
  logic [NW-1:0]  num_raw, num;
  logic [2*C-1:0] sat_num;

  logic           valid_q;
  logic [HRW-1:0] hue_rem_q, hue_div_q;
  logic [C-1:0]   sat_rem_q, sat_div_q, value_q;
  logic [L-1:0]   sat_low_q;
  logic [HRW-1:0] hue_rem_d, hue_div_d;
  logic [C-1:0]   sat_rem_d, sat_div_d;
  logic [L-1:0]   sat_low_d;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    dl = mx - mn;

    // ties go to red, then green
    if (red_i == mx) sector = SEC_RED;
    else if (green_i == mx) sector = SEC_GREEN;
    else sector = SEC_BLUE;

    // modular arithmetic; the top bit flags a negative numerator
    unique case (sector)
      SEC_RED:   num_raw = NW'(green_i) - NW'(blue_i);
      SEC_GREEN: num_raw = NW'(dl) * NW'(GreenOffset) + NW'(blue_i) - NW'(red_i);
      SEC_BLUE:  num_raw = NW'(dl) * NW'(BlueOffset) + NW'(red_i) - NW'(green_i);
      default:   num_raw = '0;
    endcase
    num = num_raw[NW-1] ? num_raw + NW'(dl) * NW'(TurnSixths) : num_raw;

    // a zero divisor becomes one; its dividend is zero so the quotient is zero
    hue_div_d = (dl == '0) ? HRW'(1) : HRW'(dl) * HRW'(TurnSixths);
    hue_rem_d = (dl == '0) ? '0 : num[HRW-1:0];

    sat_num   = {dl, {C{1'b0}}} - (2*C)'(dl);
    sat_rem_d = sat_num[2*C-1:C];
    sat_low_d = L'(sat_num[C-1:0]) << (L - C);
    sat_div_d = (mx == '0) ? C'(1) : mx;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hue_rem_q <= hue_rem_d;
      hue_div_q <= hue_div_d;
      sat_rem_q <= sat_rem_d;
      sat_div_q <= sat_div_d;
      sat_low_q <= sat_low_d;
      value_q   <= mx;
    end
  end

  assign valid_o   = valid_q;
  assign hue_rem_o = hue_rem_q;
  assign hue_div_o = hue_div_q;
  assign sat_rem_o = sat_rem_q;
  assign sat_div_o = sat_div_q;
  assign sat_low_o = sat_low_q;
  assign value_o   = value_q;

`ifndef ASSERT_OFF
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (hue_div_q != '0) && (sat_div_q != '0))
    else $error("divider operand is zero");
`endif

endmodule

FILE: rtl/rhsv_cell.sv
// Divider cell: one restoring quotient step for hue and for saturation,
// with its own pipeline register and ready chain. No package dependency.
module rhsv_cell #(
  parameter int C = 8,
  parameter int L = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  logic [C+2:0] hue_rem_i,
  input  logic [C+2:0] hue_div_i,
  input  logic [L-1:0] hue_low_i,
  input  logic [C-1:0] sat_rem_i,
  input  logic [C-1:0] sat_div_i,
  input  logic [L-1:0] sat_low_i,
  input  logic [C-1:0] value_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [C+2:0] hue_rem_o,
  output logic [C+2:0] hue_div_o,
  output logic [L-1:0] hue_low_o,
  output logic [C-1:0] sat_rem_o,
  output logic [C-1:0] sat_div_o,
  output logic [L-1:0] sat_low_o,
  output logic [C-1:0] value_o
);

  logic [C+3:0] hue_t, hue_diff;
  logic [C:0]   sat_t, sat_diff;
  logic         hue_ge, sat_ge;

  logic         valid_q;
  logic [C+2:0] hue_rem_q, hue_div_q;
  logic [C-1:0] sat_rem_q, sat_div_q, value_q;
  logic [L-1:0] hue_low_q, sat_low_q;

  // remainder stays below the divisor, so the shifted value is under twice it
  always_comb begin
    hue_t    = {hue_rem_i, hue_low_i[L-1]};
    hue_diff = hue_t - {1'b0, hue_div_i};
    hue_ge   = hue_t >= {1'b0, hue_div_i};
    sat_t    = {sat_rem_i, sat_low_i[L-1]};
    sat_diff = sat_t - {1'b0, sat_div_i};
    sat_ge   = sat_t >= {1'b0, sat_div_i};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // low word: dividend bits shift out the top, quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hue_rem_q <= hue_ge ? hue_diff[C+2:0] : hue_t[C+2:0];
      hue_div_q <= hue_div_i;
      hue_low_q <= {hue_low_i[L-2:0], hue_ge};
      sat_rem_q <= sat_ge ? sat_diff[C-1:0] : sat_t[C-1:0];
      sat_div_q <= sat_div_i;
      sat_low_q <= {sat_low_i[L-2:0], sat_ge};
      value_q   <= value_i;
    end
  end

  assign valid_o   = valid_q;
  assign hue_rem_o = hue_rem_q;
  assign hue_div_o = hue_div_q;
  assign hue_low_o = hue_low_q;
  assign sat_rem_o = sat_rem_q;
  assign sat_div_o = sat_div_q;
  assign sat_low_o = sat_low_q;
  assign value_o   = value_q;

`ifndef ASSERT_OFF
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (hue_rem_q < hue_div_q) && (sat_rem_q < sat_div_q))
    else $error("partial remainder not below divisor");
`endif

endmodule

FILE: rtl/rgb_to_hsv_converter.sv
// RGB to HSV pixel converter, top level.
// Depends on rhsv_pkg, rhsv_front and rhsv_cell.
//
// Input channel: red_i/green_i/blue_i with in_valid_i; the block drives
// in_stall_o. Output channel: hue_o/saturation_o/value_o with out_valid_o;
// the receiver drives out_stall_i. A transfer happens where valid is high
// and stall is low.
// One pixel is taken per clock while in_stall_o is low. The pipeline is
// one front stage for max/min and divider operands, then one divider cell
// per quotient bit. Each cell does one restoring step for both the hue and
// the saturation division, so the cell count sets the latency.
// Every stage has its own valid bit and a ready chain: when the receiver
// stalls, the last cell holds its result and earlier stages keep filling
// empty slots; in_stall_o rises only once every stage is occupied.
// Reset clears all valid bits; the data registers are not reset.
module rgb_to_hsv_converter #(
  parameter int CHANNEL_BITS = 8,
  parameter int HUE_BITS     = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [HUE_BITS-1:0]     hue_o,
  output logic [CHANNEL_BITS-1:0] saturation_o,
  output logic [CHANNEL_BITS-1:0] value_o
);
  import rhsv_pkg::*;

  localparam int C = CHANNEL_BITS;
  localparam int L = div_steps(CHANNEL_BITS, HUE_BITS);

  logic         valid   [L+1];
  logic         ready   [L+1];
  logic [C+2:0] hue_rem [L+1];
  logic [C+2:0] hue_div [L+1];
  logic [L-1:0] hue_low [L+1];
  logic [C-1:0] sat_rem [L+1];
  logic [C-1:0] sat_div [L+1];
  logic [L-1:0] sat_low [L+1];
  logic [C-1:0] value   [L+1];
  logic         front_ready;

  rhsv_front #(.C(C), .H(HUE_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (front_ready),
    .red_i     (red_i),
    .green_i   (green_i),
    .blue_i    (blue_i),
    .valid_o   (valid[0]),
    .ready_i   (ready[0]),
    .hue_rem_o (hue_rem[0]),
    .hue_div_o (hue_div[0]),
    .sat_rem_o (sat_rem[0]),
    .sat_div_o (sat_div[0]),
    .sat_low_o (sat_low[0]),
    .value_o   (value[0])
  );

  assign hue_low[0] = '0;
  assign in_stall_o = !front_ready;

  for (genvar k = 0; k < L; k++) begin : g_cell
    rhsv_cell #(.C(C), .L(L)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (valid[k]),
      .ready_o   (ready[k]),
      .hue_rem_i (hue_rem[k]),
      .hue_div_i (hue_div[k]),
      .hue_low_i (hue_low[k]),
      .sat_rem_i (sat_rem[k]),
      .sat_div_i (sat_div[k]),
      .sat_low_i (sat_low[k]),
      .value_i   (value[k]),
      .valid_o   (valid[k+1]),
      .ready_i   (ready[k+1]),
      .hue_rem_o (hue_rem[k+1]),
      .hue_div_o (hue_div[k+1]),
      .hue_low_o (hue_low[k+1]),
      .sat_rem_o (sat_rem[k+1]),
      .sat_div_o (sat_div[k+1]),
      .sat_low_o (sat_low[k+1]),
      .value_o   (value[k+1])
    );
  end

  assign ready[L] = !out_stall_i;

  // both quotients carry L bits; the top bits are the results
  assign out_valid_o  = valid[L];
  assign hue_o        = hue_low[L][L-1 -: HUE_BITS];
  assign saturation_o = sat_low[L][L-1 -: C];
  assign value_o      = value[L];

`ifndef ASSERT_OFF
  a_black_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (value_o == '0) |-> (saturation_o == '0))
    else $error("black pixel with nonzero saturation");
`endif
`ifndef ASSERT_OFF
  a_grey_no_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (saturation_o == '0) |-> (hue_o == '0))
    else $error("grey pixel with nonzero hue");
`endif

endmodule

FILE: dv/rgb_to_hsv_checker.sv
// Checker for rgb_to_hsv_converter: watches both channels, predicts each result
// from the accepted pixel and compares the results in order.
// Depends on rhsv_pkg for the hue sector offsets.
module rgb_to_hsv_checker #(
  parameter int CHANNEL_BITS = 8,
  parameter int HUE_BITS     = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [HUE_BITS-1:0]     hue_i,
  input  logic [CHANNEL_BITS-1:0] saturation_i,
  input  logic [CHANNEL_BITS-1:0] value_i,
  output int                      mismatch_count_o,
  output int                      pending_o
);
  import rhsv_pkg::*;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] value;
  } hsv_t;

  localparam longint ChanFull = (64'd1 << CHANNEL_BITS) - 1;

  hsv_t hsv_expected_q[$];
  int   mismatch_count = 0;
  int   pending        = 0;

  assign mismatch_count_o = mismatch_count;
  assign pending_o        = pending;

  function automatic hsv_t hsv_predict(input logic [CHANNEL_BITS-1:0] r,
                                       input logic [CHANNEL_BITS-1:0] g,
                                       input logic [CHANNEL_BITS-1:0] b);
    longint red, green, blue, mx, mn, delta, num;
    hsv_t   res;
    red   = longint'(r);
    green = longint'(g);
    blue  = longint'(b);
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;
    res = '0;
    res.value = CHANNEL_BITS'(mx);
    if (mx != 0) res.saturation = CHANNEL_BITS'((ChanFull * delta) / mx);
    // grey and black pixels keep hue at zero
    if (delta != 0) begin
      // ties resolve red first, then green
      if (red == mx) num = green - blue;
      else if (green == mx) num = GreenOffset * delta + blue - red;
      else num = BlueOffset * delta + red - green;
      if (num < 0) num += TurnSixths * delta;
      res.hue = HUE_BITS'((num << HUE_BITS) / (TurnSixths * delta));
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    hsv_t got, want;
    if (rst_ni) begin
      // check before push: a pixel never comes out in the cycle it goes in
      if (out_valid_i && !out_stall_i) begin
        got = '{hue_i, saturation_i, value_i};
        if (hsv_expected_q.size() == 0) begin
          $error("result transfer with no pixel pending: hue %0d sat %0d value %0d",
                 got.hue, got.saturation, got.value);
          mismatch_count++;
        end else begin
          want = hsv_expected_q.pop_front();
          if (got.hue !== want.hue) begin
            $error("hue: expected %0d, actual %0d", want.hue, got.hue);
            mismatch_count++;
          end
          if (got.saturation !== want.saturation) begin
            $error("saturation: expected %0d, actual %0d", want.saturation, got.saturation);
            mismatch_count++;
          end
          if (got.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, got.value);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) hsv_expected_q.push_back(hsv_predict(red_i, green_i, blue_i));
    end
    pending = hsv_expected_q.size();
  end

endmodule

FILE: dv/tb_rgb_to_hsv_converter.sv
// Testbench top for rgb_to_hsv_converter: clock, reset, pixel stimulus and
// result-side stall, verdict. Depends on the block and rgb_to_hsv_checker.
module tb_rgb_to_hsv_converter;

  localparam int ChanBits      = 8;
  localparam int HueBits       = 16;
  localparam int Latency       = 17;
  localparam int HoldOffCycles = 200;
  localparam int RandomPerPass = 650;
  localparam int CycleLimit    = 400000;

  // r, g, b packed high to low
  localparam logic [23:0] DirectedPixels [21] = '{
    24'h000000, 24'hffffff, 24'h808080, 24'h010101, 24'hff0000, 24'h00ff00,
    24'h0000ff, 24'hffff00, 24'h00ffff, 24'hff00ff, 24'hff0001, 24'h010000,
    24'h000100, 24'h000001, 24'hfffe00, 24'h0001ff, 24'haa55ff, 24'hc86432,
    24'h3264c8, 24'h0ac864, 24'hfe00ff
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ChanBits-1:0] red_i;
  logic [ChanBits-1:0] green_i;
  logic [ChanBits-1:0] blue_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [HueBits-1:0]  hue_o;
  logic [ChanBits-1:0] saturation_o;
  logic [ChanBits-1:0] value_o;

  int mismatch_count;
  int pending;
  int src_idle_pct  = 32;
  int sink_idle_pct = 78;
  bit hold_off_req  = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  rgb_to_hsv_converter #(
    .CHANNEL_BITS(ChanBits),
    .HUE_BITS    (HueBits)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hue_o       (hue_o),
    .saturation_o(saturation_o),
    .value_o     (value_o)
  );

  rgb_to_hsv_checker #(
    .CHANNEL_BITS(ChanBits),
    .HUE_BITS    (HueBits)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hue_i           (hue_o),
    .saturation_i    (saturation_o),
    .value_i         (value_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("** rgb_to_hsv_converter: FAILED **");
    $finish;
  end

  // result side: random stall, or a long hold-off on request
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left   = 0;
    hold_taken  = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldOffCycles;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < sink_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_pixel(input logic [ChanBits-1:0] r, input logic [ChanBits-1:0] g,
                            input logic [ChanBits-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    red_i      = r;
    green_i    = g;
    blue_i     = b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_pixel();
    logic [ChanBits-1:0] a, b, c;
    a = ChanBits'($urandom);
    b = ChanBits'($urandom);
    c = ChanBits'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: ;
      5: begin
        b = a;
        c = a;
      end
      6: b = a;
      7: c = b;
      8: begin
        b = a - ChanBits'($urandom_range(3));
        c = a + ChanBits'($urandom_range(3));
      end
      default: begin
        a = $urandom_range(1) ? '1 : '0;
        b = $urandom_range(1) ? '1 : '0;
        c = $urandom_range(1) ? '1 : '0;
      end
    endcase
    // rotate so every tie and extreme lands on each channel
    case ($urandom_range(2))
      0:       send_pixel(a, b, c);
      1:       send_pixel(b, c, a);
      default: send_pixel(c, a, b);
    endcase
  endtask

  task automatic wait_drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    red_i      = '0;
    green_i    = '0;
    blue_i     = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirectedPixels[i])
      send_pixel(DirectedPixels[i][23:16], DirectedPixels[i][15:8], DirectedPixels[i][7:0]);
    repeat (RandomPerPass - $size(DirectedPixels)) send_random_pixel();
    wait_drain();

    src_idle_pct  = 78;
    sink_idle_pct = 32;
    repeat (RandomPerPass) send_random_pixel();
    wait_drain();

    // full rate; the hold-off fills the pipeline and stalls the input
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_off_req  = 1'b1;
    repeat (RandomPerPass) send_random_pixel();
    wait_drain();

    repeat (Latency + 3) @(negedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("** rgb_to_hsv_converter: PASSED **");
    end else begin
      $display("** rgb_to_hsv_converter: FAILED **");
    end
    $finish;
  end

endmodule
